// ----- hdl/tpcs_pkg.sv -----
// Shared types, constants and lookup functions for the timer prescaler solver.
package tpcs_pkg;

  localparam int unsigned      CLK_W              = 32;
  localparam int unsigned      SHIFT_COUNT        = 5;
  localparam int unsigned      NUM_PRESCALERS_DEF = 5;
  localparam logic [31:0]      COMPARE_MAX_DEF    = 32'd65535;
  localparam logic [CLK_W-1:0] CPU_CLOCK_RESET    = 32'd16000000;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_NEXT = 10'b00_0000_0010,
    S_DIV  = 10'b00_0000_0100,
    S_OC   = 10'b00_0000_1000,
    S_Q    = 10'b00_0001_0000,
    S_E    = 10'b00_0010_0000,
    S_W    = 10'b00_0100_0000,
    S_SEL  = 10'b00_1000_0000,
    S_PUSH = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  // Prescaler shift for each candidate position.
  function automatic logic [3:0] shift_of(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd6;
      3'd3:    s = 4'd8;
      3'd4:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Base scale of 100 times the prescale-dependent power of ten.
  function automatic logic [16:0] mult1_of(input logic [2:0] idx);
    logic [16:0] m;
    case (idx)
      3'd2:    m = 17'd1000;
      3'd3:    m = 17'd10000;
      3'd4:    m = 17'd100000;
      default: m = 17'd100;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] dig1_of(input logic [2:0] idx);
    logic [1:0] d;
    case (idx)
      3'd2:    d = 2'd1;
      3'd3:    d = 2'd2;
      3'd4:    d = 2'd3;
      default: d = 2'd0;
    endcase
    return d;
  endfunction

  // Digits added by the size of the compare count.
  function automatic logic [2:0] dig2_of(input logic [63:0] oc);
    logic [2:0] d;
    if (oc > 64'd10000)     d = 3'd4;
    else if (oc > 64'd1000) d = 3'd3;
    else if (oc > 64'd100)  d = 3'd2;
    else if (oc > 64'd10)   d = 3'd1;
    else                    d = 3'd0;
    return d;
  endfunction

  function automatic logic [13:0] pow10_14(input logic [2:0] n);
    logic [13:0] p;
    case (n)
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  function automatic logic [23:0] pow10_24(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      3'd7:    p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/timer_prescaler_compare_solver.sv -----
// Each usable shift runs four 64-bit divisions plus seven steps; a shift failing the checks is
// skipped, and one whose compare count overflows ends after its first division. Output stalls
// hold the sequencer in its push and finish states.
// Throughput: one request at a time; the next is taken once the sequencer is back in idle.
// Reset (rst_n low, synchronous) clears the sequencer and output valid, and loads the
// clock register with 16 MHz.
module timer_prescaler_compare_solver #(
  parameter int unsigned NUM_PRESCALERS = tpcs_pkg::NUM_PRESCALERS_DEF,
  parameter logic [31:0] COMPARE_MAX    = tpcs_pkg::COMPARE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tpcs_pkg::CLK_W-1:0] cfg_cpu_clock_hz,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_request_hz,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_entry_index,
  output logic [2:0]                 out_prescale_code,
  output logic [15:0]                out_compare_value,
  output logic signed [7:0]          out_error_whole,
  output logic [23:0]                out_error_fraction,
  output logic [2:0]                 out_error_digits,
  output logic [2:0]                 out_best_index,
  output logic                       out_none_found,
  output logic                       out_last
);
  import tpcs_pkg::*;

  localparam logic [2:0] CNT = (NUM_PRESCALERS < SHIFT_COUNT) ?
                               3'(NUM_PRESCALERS) : 3'(SHIFT_COUNT);

  state_t state_r, state_nxt, ret_r;

  logic [31:0] clk_hz_r, req_r;
  logic [15:0] oc_r;
  logic [2:0]  idx_r, n_r, sel_r, dig_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0]  cnt_r;
  logic [48:0] b_r;
  logic [7:0]  cw_r, bw_r;
  logic [23:0] cf_r, bf_r;
  logic [2:0]  bd_r;
  logic [47:0] pn_r, pb_r;
  logic        have_pend_r;
  logic [2:0]  pidx_r, pcode_r, pdig_r, psel_r;
  logic [15:0] poc_r;
  logic [7:0]  pw_r;
  logic [23:0] pf_r;

  logic        out_valid_r, out_none_r, out_last_r;
  logic [2:0]  out_idx_r, out_code_r, out_dig_r, out_best_r;
  logic [15:0] out_oc_r;
  logic [7:0]  out_w_r;
  logic [23:0] out_f_r;

  logic [3:0]  sh;
  logic [31:0] shifted, mask;
  logic        usable;
  logic [32:0] div_tr;
  logic        div_ge;
  logic [31:0] div_rem;
  logic        out_free, take, oc_ok, out_load;
  logic [2:0]  dig_full;
  logic [48:0] qp;

  assign sh      = shift_of(idx_r);
  assign shifted = clk_hz_r >> sh;
  assign mask    = (32'd1 << sh) - 32'd1;
  // A zero request reaches nothing, so it ends in the none-found result.
  assign usable  = (req_r != 32'd0) && ((clk_hz_r & mask) == 32'd0) && (shifted > req_r);
  assign oc_ok   = quo_r <= 64'(COMPARE_MAX);
  assign dig_full = 3'(dig1_of(idx_r)) + dig2_of(quo_r);
  assign qp      = quo_r[48:0] - b_r;

  assign div_tr  = {rem_r, quo_r[63]};
  assign div_ge  = div_tr >= {1'b0, dvs_r};
  assign div_rem = div_ge ? 32'(div_tr - {1'b0, dvs_r}) : div_tr[31:0];

  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((state_r == S_PUSH) && have_pend_r && out_free) ||
                    ((state_r == S_FIN) && out_free);
  // Later entry wins a tie once the fractions sit at the same digit count.
  assign take = (n_r == 3'd0) || (cw_r < bw_r) || ((cw_r == bw_r) && (pn_r <= pb_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_NEXT;
      S_NEXT: begin
        if (idx_r >= CNT) state_nxt = S_FIN;
        else if (usable)  state_nxt = S_DIV;
      end
      S_DIV:  if (cnt_r == 6'd63) state_nxt = ret_r;
      S_OC:   state_nxt = oc_ok ? S_DIV : S_NEXT;
      S_Q:    state_nxt = S_DIV;
      S_E:    state_nxt = S_DIV;
      S_W:    state_nxt = S_SEL;
      S_SEL:  state_nxt = S_PUSH;
      S_PUSH: if (!have_pend_r || out_free) state_nxt = S_NEXT;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_OC;
      clk_hz_r    <= CPU_CLOCK_RESET;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) clk_hz_r <= cfg_cpu_clock_hz;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r       <= in_request_hz;
            idx_r       <= '0;
            n_r         <= '0;
            have_pend_r <= 1'b0;
          end
        end
        S_NEXT: begin
          if (idx_r < CNT) begin
            if (usable) begin
              quo_r <= 64'(shifted);
              rem_r <= '0;
              dvs_r <= req_r;
              cnt_r <= '0;
              ret_r <= S_OC;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        S_DIV: begin
          quo_r <= {quo_r[62:0], div_ge};
          rem_r <= div_rem;
          cnt_r <= cnt_r + 6'd1;
        end
        S_OC: begin
          if (oc_ok) begin
            oc_r  <= quo_r[15:0];
            dig_r <= dig_full;
            quo_r <= 64'(shifted) * 64'(mult1_of(idx_r));
            b_r   <= 49'(req_r) * 49'(mult1_of(idx_r));
            dvs_r <= quo_r[31:0];
            rem_r <= '0;
            cnt_r <= '0;
            ret_r <= S_Q;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        S_Q: begin
          // The quotient never falls below the exact target, so the error is non-negative.
          quo_r <= 64'(qp) * 64'(pow10_14(dig_r - 3'(dig1_of(idx_r))));
          dvs_r <= req_r;
          rem_r <= '0;
          cnt_r <= '0;
          ret_r <= S_E;
        end
        S_E: begin
          dvs_r <= 32'(pow10_24(dig_r));
          rem_r <= '0;
          cnt_r <= '0;
          ret_r <= S_W;
        end
        S_W: begin
          cw_r <= quo_r[7:0];
          cf_r <= rem_r[23:0];
          pn_r <= 48'(rem_r[23:0]) *
                  48'(pow10_24((bd_r > dig_r) ? (bd_r - dig_r) : 3'd0));
          pb_r <= 48'(bf_r) * 48'(pow10_24((dig_r > bd_r) ? (dig_r - bd_r) : 3'd0));
        end
        S_SEL: begin
          if (take) begin
            sel_r <= n_r;
            bw_r  <= cw_r;
            bf_r  <= cf_r;
            bd_r  <= dig_r;
          end
        end
        S_PUSH: begin
          if (!have_pend_r || out_free) begin
            if (have_pend_r) begin
              out_idx_r   <= pidx_r;
              out_code_r  <= pcode_r;
              out_oc_r    <= poc_r;
              out_w_r     <= pw_r;
              out_f_r     <= pf_r;
              out_dig_r   <= pdig_r;
              out_best_r  <= psel_r;
              out_none_r  <= 1'b0;
              out_last_r  <= 1'b0;
            end
            have_pend_r <= 1'b1;
            pidx_r      <= n_r;
            pcode_r     <= idx_r + 3'd1;
            poc_r       <= oc_r;
            pw_r        <= cw_r;
            pf_r        <= cf_r;
            pdig_r      <= dig_r;
            psel_r      <= sel_r;
            n_r         <= n_r + 3'd1;
            idx_r       <= idx_r + 3'd1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            out_none_r  <= !have_pend_r;
            out_idx_r   <= have_pend_r ? pidx_r  : 3'd0;
            out_code_r  <= have_pend_r ? pcode_r : 3'd0;
            out_oc_r    <= have_pend_r ? poc_r   : 16'd0;
            out_w_r     <= have_pend_r ? pw_r    : 8'd0;
            out_f_r     <= have_pend_r ? pf_r    : 24'd0;
            out_dig_r   <= have_pend_r ? pdig_r  : 3'd0;
            out_best_r  <= have_pend_r ? psel_r  : 3'd0;
            have_pend_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready          = 1'b1;
  assign in_ready           = state_r == S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_entry_index    = out_idx_r;
  assign out_prescale_code  = out_code_r;
  assign out_compare_value  = out_oc_r;
  assign out_error_whole    = out_w_r;
  assign out_error_fraction = out_f_r;
  assign out_error_digits   = out_dig_r;
  assign out_best_index     = out_best_r;
  assign out_none_found     = out_none_r;
  assign out_last           = out_last_r;

`ifndef NO_ASSERTIONS
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != 32'd0))
    else $error("divider started with a zero divisor");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> out_last_r)
    else $error("none-found result is not the final one");
  a_pend_idx: assert property (@(posedge clk) disable iff (!rst_n)
    have_pend_r |-> (pidx_r < CNT))
    else $error("held result carries an out-of-range entry index");
`endif

endmodule
